[hw/rtl/spherical_shell_zone_locator_defines.svh]
// Assertion macros for the spherical shell zone locator.
// Included by the RTL files that carry concurrent assertions.
`ifndef SPHERICAL_SHELL_ZONE_LOCATOR_DEFINES_SVH
`define SPHERICAL_SHELL_ZONE_LOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSZ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SSZ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSZ_ASSERT(lbl, clk, rst, prop, msg)
`define SSZ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/ssz_pkg.sv]
// Types and constants of the spherical shell zone locator.
// No dependencies; used by the top level.
package ssz_pkg;

  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 32;
  localparam int SQ_W     = 64;
  localparam int ZONE_W   = 8;
  localparam int CNT_W    = 9;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] STATUS_INSIDE = 2'd0;
  localparam logic [1:0] STATUS_BELOW  = 2'd1;
  localparam logic [1:0] STATUS_BEYOND = 2'd2;

  // register select is paddr[2], word aligned
  localparam logic REG_INNER_RADIUS = 1'b0;
  localparam logic REG_ZONE_COUNT   = 1'b1;

  typedef struct packed {
    logic                       func;
    logic [ZONE_W-1:0]          load_index;
    logic [RADIUS_W-1:0]        load_radius;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ZONE_W-1:0] zone;
  } res_item_t;

endpackage

[hw/rtl/ssz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/spherical_shell_zone_locator.sv]
// Spherical shell zone locator: radius table, squaring sequencer, binary search.
// Depends on ssz_pkg, ssz_ram and spherical_shell_zone_locator_defines.svh.
//
//   channel   signals                                 direction
//   cmd       cmd_valid, cmd_ready, cmd (cmd_item_t)   in
//   res       res_valid, res_ready, res (res_item_t)   out
//   apb       psel, penable, pwrite, paddr, pwdata,    in/out
//             prdata, pready
//
// A load item writes the table at acceptance. A query runs MX to CO, then k
// search steps of SA, SM, SC (k at most 9 for 256 shells), and stops at CI or
// CO when the point is below or beyond the shells. One 32x32 squaring multiplier
// and the registered table read port serve all steps. Reset clears the sequencer,
// the result valid and the inner radius, sets the zone count to one and leaves
// the table undefined until loaded. A result not taken holds the sequencer.
`include "spherical_shell_zone_locator_defines.svh"

module spherical_shell_zone_locator #(
  parameter int MAX_ZONES  = 256,
  parameter int COORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  ssz_pkg::cmd_item_t          cmd,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ssz_pkg::res_item_t          res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssz_pkg::PADDR_W-1:0] paddr,
  input  logic [ssz_pkg::PDATA_W-1:0] pwdata,
  output logic [ssz_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  import ssz_pkg::*;

  localparam int TABLE_DEPTH = (MAX_ZONES < 256) ? MAX_ZONES : 256;
  localparam int AW          = $clog2(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_MZ   = 4'd3;
  localparam logic [3:0] S_MI   = 4'd4;
  localparam logic [3:0] S_CI   = 4'd5;
  localparam logic [3:0] S_MO   = 4'd6;
  localparam logic [3:0] S_CO   = 4'd7;
  localparam logic [3:0] S_SA   = 4'd8;
  localparam logic [3:0] S_SM   = 4'd9;
  localparam logic [3:0] S_SC   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  function automatic logic [COORD_W-1:0] coord_mag(input logic [COORD_W-1:0] raw);
    logic signed [COORD_BITS-1:0] low;
    logic signed [COORD_W-1:0]    ext;
    low = raw[COORD_BITS-1:0];
    ext = COORD_W'(low);
    return ext[COORD_W-1] ? COORD_W'(-ext) : COORD_W'(ext);
  endfunction

  logic [3:0]          state;
  logic [RADIUS_W-1:0] inner_radius;
  logic [CNT_W-1:0]    zone_count;
  logic [COORD_W-1:0]  mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]     acc;
  logic [SQ_W-1:0]     prod;
  logic [CNT_W-1:0]    lo, count, mid, half;
  logic [1:0]          fin_status;
  logic [ZONE_W-1:0]   fin_zone;

  logic [CNT_W-1:0]    shells;
  logic [CNT_W-1:0]    last_shell;
  logic [CNT_W-1:0]    mid_sum;
  logic [RADIUS_W-1:0] op;
  logic [SQ_W-1:0]     sq;
  logic [AW-1:0]       raddr;
  logic [RADIUS_W-1:0] rdata;
  logic                tbl_we;
  logic                cmd_take;
  logic                cfg_wr;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_take  = cmd_valid && cmd_ready;
  assign tbl_we    = cmd_take && (cmd.func == FUNC_LOAD) &&
                     (32'(cmd.load_index) < 32'(MAX_ZONES));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ZONE_COUNT) ? PDATA_W'(zone_count) : inner_radius;

  always_comb begin
    priority if (zone_count == '0) begin
      shells = CNT_W'(1);
    end else if (zone_count > CNT_W'(TABLE_DEPTH)) begin
      shells = CNT_W'(TABLE_DEPTH);
    end else begin
      shells = zone_count;
    end
  end

  assign last_shell = shells - CNT_W'(1);
  assign mid_sum    = lo + (count >> 1);

  always_comb begin
    unique case (state)
      S_MX:    op = mag_x;
      S_MY:    op = mag_y;
      S_MZ:    op = mag_z;
      S_MI:    op = inner_radius;
      default: op = rdata;
    endcase
  end

  assign sq    = op * op;
  assign raddr = (state == S_CI) ? last_shell[AW-1:0] : mid_sum[AW-1:0];

  ssz_ram #(
    .WIDTH(RADIUS_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(cmd.load_index[AW-1:0]),
    .wdata(cmd.load_radius),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= '0;
      zone_count   <= CNT_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ZONE_COUNT) begin
        zone_count <= pwdata[CNT_W-1:0];
      end else begin
        inner_radius <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_take && (cmd.func == FUNC_QUERY)) begin
            state <= S_MX;
          end
        end
        S_MX:   state <= S_MY;
        S_MY:   state <= S_MZ;
        S_MZ:   state <= S_MI;
        S_MI:   state <= S_CI;
        S_CI:   state <= (acc < prod) ? S_DONE : S_MO;
        S_MO:   state <= S_CO;
        S_CO:   state <= (acc >= prod) ? S_DONE : S_SA;
        S_SA:   state <= (count == '0) ? S_DONE : S_SM;
        S_SM:   state <= S_SC;
        S_SC:   state <= S_SA;
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mag_x <= coord_mag(cmd.pos_x);
        mag_y <= coord_mag(cmd.pos_y);
        mag_z <= coord_mag(cmd.pos_z);
      end
      S_MX: prod <= sq;
      S_MY: begin
        prod <= sq;
        acc  <= prod;
      end
      S_MZ, S_MI: begin
        prod <= sq;
        acc  <= acc + prod;
      end
      S_CI: begin
        fin_status <= STATUS_BELOW;
        fin_zone   <= '0;
      end
      S_MO: prod <= sq;
      S_CO: begin
        fin_status <= STATUS_BEYOND;
        fin_zone   <= '0;
        lo         <= '0;
        count      <= shells;
      end
      S_SA: begin
        mid        <= mid_sum;
        half       <= count >> 1;
        fin_status <= STATUS_INSIDE;
        fin_zone   <= (lo >= shells) ? ZONE_W'(last_shell) : ZONE_W'(lo);
      end
      S_SM: prod <= sq;
      S_SC: begin
        if (prod <= acc) begin
          lo    <= mid + CNT_W'(1);
          count <= count - half - CNT_W'(1);
        end else begin
          count <= half;
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          res.status <= fin_status;
          res.zone   <= fin_zone;
        end
      end
      default: ;
    endcase
  end

  `SSZ_ASSERT(a_load_no_result, clk, rst, cmd_take && (cmd.func == FUNC_LOAD) |=> (state == S_IDLE) && !(res_valid && !$past(res_valid)), "load item started work or made a result")
  `SSZ_ASSERT(a_zone_only_inside, clk, rst, res_valid && (res.zone != '0) |-> (res.status == STATUS_INSIDE), "nonzero zone outside a shell")
  `SSZ_ASSERT(a_status_code, clk, rst, res_valid |-> (res.status == STATUS_INSIDE) || (res.status == STATUS_BELOW) || (res.status == STATUS_BEYOND), "undefined status code")
  `SSZ_ASSERT(a_search_shrinks, clk, rst, (state == S_SC) |=> (count < $past(count)), "search range did not shrink")
  `SSZ_ASSERT(a_zone_in_range, clk, rst, res_valid && (res.status == STATUS_INSIDE) |-> (CNT_W'(res.zone) < shells), "zone beyond shells in use")

endmodule

[sim/tb_spherical_shell_zone_locator.sv]
// Testbench for spherical_shell_zone_locator: loads the shell radius table, sends
// query items and checks every zone result against an in-bench predictor.
// Depends on ssz_pkg and the block's RTL only.
module tb_spherical_shell_zone_locator;
  timeunit 1ns;
  timeprecision 1ps;
  import ssz_pkg::*;

  localparam int SHELLS = 256;
  localparam int SETTLE = 40;
  localparam int HOLD = 600;
  localparam int LIMIT = 1000000;
  localparam logic [COORD_W-1:0] HALF_RANGE = 32'h8000_0000;

  typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_item_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_item_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  spherical_shell_zone_locator dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the block's table and registers
  logic [RADIUS_W-1:0] radius_tbl [SHELLS];
  logic [RADIUS_W-1:0] inner_r = '0;
  logic [CNT_W-1:0] zone_cnt = 1;
  res_item_t zone_q[$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int n_loads = 0;
  int n_cfg = 0;
  int n_status [3] = '{0, 0, 0};
  bit idle_on = 1'b1;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  rx_mode_e rx_mode = RX_STEADY;
  int rx_mode_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, zone_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  function automatic logic [SQ_W-1:0] square_mag(logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] a;
    logic [SQ_W-1:0] m;
    a = v[COORD_W-1] ? (~v + 32'd1) : v;
    m = SQ_W'(a);
    return m * m;
  endfunction

  function automatic logic [SQ_W-1:0] square_rad(logic [RADIUS_W-1:0] r);
    logic [SQ_W-1:0] m;
    m = SQ_W'(r);
    return m * m;
  endfunction

  function automatic int shells_used();
    int n;
    n = zone_cnt;
    if (n == 0) n = 1;
    if (n > SHELLS) n = SHELLS;
    return n;
  endfunction

  function automatic res_item_t locate_zone(cmd_item_t c);
    res_item_t r;
    logic [SQ_W-1:0] d2;
    int n, lo, cnt, half, mid;
    r.status = STATUS_INSIDE;
    r.zone = '0;
    d2 = square_mag(c.pos_x) + square_mag(c.pos_y) + square_mag(c.pos_z);
    n = shells_used();
    if (d2 < square_rad(inner_r)) begin
      r.status = STATUS_BELOW;
    end else if (d2 >= square_rad(radius_tbl[n-1])) begin
      r.status = STATUS_BEYOND;
    end else begin
      // upper bound: first shell whose squared radius exceeds d2
      lo = 0;
      cnt = n;
      while (cnt > 0) begin
        half = cnt / 2;
        mid = lo + half;
        if (square_rad(radius_tbl[mid]) <= d2) begin
          lo = mid + 1;
          cnt -= half + 1;
        end else begin
          cnt = half;
        end
      end
      if (lo >= n) lo = n - 1;
      r.zone = ZONE_W'(lo);
    end
    return r;
  endfunction

  function automatic void apply_item(cmd_item_t c);
    if (c.func == FUNC_LOAD) begin
      radius_tbl[c.load_index] = c.load_radius;
      n_loads++;
    end else begin
      zone_q.push_back(locate_zone(c));
    end
  endfunction

  function automatic cmd_item_t make_load(logic [ZONE_W-1:0] idx, logic [RADIUS_W-1:0] rad);
    cmd_item_t c;
    c.func = FUNC_LOAD;
    c.load_index = idx;
    c.load_radius = rad;
    c.pos_x = $urandom;
    c.pos_y = $urandom;
    c.pos_z = $urandom;
    return c;
  endfunction

  function automatic cmd_item_t make_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                           logic [COORD_W-1:0] z);
    cmd_item_t c;
    c.func = FUNC_QUERY;
    c.load_index = $urandom;
    c.load_radius = $urandom;
    c.pos_x = x;
    c.pos_y = y;
    c.pos_z = z;
    return c;
  endfunction

  // point at exactly rad on a random axis; rad must not exceed 2^31
  function automatic cmd_item_t on_axis(logic [RADIUS_W-1:0] rad);
    logic [COORD_W-1:0] v;
    logic [COORD_W-1:0] p [3];
    v = ($urandom_range(0, 1) == 1 || rad == HALF_RANGE) ? (~rad + 32'd1) : rad;
    p = '{default: '0};
    p[$urandom_range(0, 2)] = v;
    return make_query(p[0], p[1], p[2]);
  endfunction

  function automatic cmd_item_t scattered_point();
    int s;
    s = $urandom_range(0, 31);
    return make_query($signed($urandom) >>> $urandom_range(s, 31),
                      $signed($urandom) >>> $urandom_range(s, 31),
                      $signed($urandom) >>> $urandom_range(s, 31));
  endfunction

  // point on or next to a shell boundary or the inner radius, else a scattered point
  function automatic cmd_item_t shell_point();
    logic [RADIUS_W-1:0] base;
    logic [RADIUS_W:0] rad;
    int j;
    j = $urandom_range(0, shells_used() - 1);
    base = ($urandom_range(0, 4) == 0) ? inner_r : radius_tbl[j];
    rad = {1'b0, base} + 33'($urandom_range(0, 2)) - 33'd1;
    if (rad > {1'b0, HALF_RANGE}) return scattered_point();
    return on_axis(rad[RADIUS_W-1:0]);
  endfunction

  // rewrite one entry with a value that keeps the table increasing where possible
  function automatic cmd_item_t reshape_load();
    int i;
    logic [RADIUS_W:0] lo_b, hi_b, val;
    i = $urandom_range(0, SHELLS - 1);
    lo_b = (i == 0) ? 33'd0 : {1'b0, radius_tbl[i-1]} + 33'd1;
    hi_b = (i == SHELLS - 1) ? 33'h0_FFFF_FFFF : {1'b0, radius_tbl[i+1]} - 33'd1;
    if (hi_b >= lo_b && hi_b <= 33'h0_FFFF_FFFF)
      val = lo_b + ({1'b0, $urandom} % (hi_b - lo_b + 33'd1));
    else
      val = {1'b0, radius_tbl[i]};
    return make_load(ZONE_W'(i), val[RADIUS_W-1:0]);
  endfunction

  task automatic send_item(cmd_item_t c);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      if (idle_on) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    apply_item(c);
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    while (zone_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shells(logic [RADIUS_W-1:0] inner, logic [CNT_W-1:0] count);
    logic [PDATA_W-1:0] rd;
    settle();
    apb_access(1'b1, {REG_INNER_RADIUS, 2'b00}, inner, rd);
    inner_r = inner;
    apb_access(1'b1, {REG_ZONE_COUNT, 2'b00}, PDATA_W'(count), rd);
    zone_cnt = count;
    apb_access(1'b0, {REG_INNER_RADIUS, 2'b00}, '0, rd);
    if (rd !== inner) note_mismatch("inner_radius readback", inner, rd);
    apb_access(1'b0, {REG_ZONE_COUNT, 2'b00}, '0, rd);
    if (rd[CNT_W-1:0] !== count) note_mismatch("zone_count readback", count, rd[CNT_W-1:0]);
    n_cfg++;
  endtask

  task automatic random_shells();
    logic [RADIUS_W-1:0] inner;
    logic [CNT_W-1:0] cnt;
    case ($urandom_range(0, 5))
      0: cnt = '0;
      1: cnt = SHELLS;
      2: cnt = $urandom_range(SHELLS + 1, 511);
      default: cnt = $urandom_range(1, SHELLS);
    endcase
    case ($urandom_range(0, 3))
      0: inner = '0;
      1: inner = radius_tbl[$urandom_range(0, SHELLS - 1)];
      2: inner = $urandom >> $urandom_range(0, 31);
      default: inner = radius_tbl[0] >> 1;
    endcase
    set_shells(inner, cnt);
  endtask

  task automatic run_mix(int items, int load_pct, bit keep_order);
    repeat (items) begin
      if ($urandom_range(0, 99) < load_pct)
        send_item(keep_order ? reshape_load()
                             : make_load($urandom, $urandom >> $urandom_range(0, 8)));
      else
        send_item($urandom_range(0, 1) ? shell_point() : scattered_point());
    end
  endtask

  // increasing radii with steps of mixed scale; the last slot holds the largest radius
  task automatic test_table_load();
    logic [RADIUS_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < SHELLS; i++) begin
      acc += 1 + ($urandom >> $urandom_range(9, 31));
      if (i == SHELLS - 1) acc = '1;
      send_item(make_load(ZONE_W'(i), acc));
    end
  endtask

  task automatic test_corner_points();
    set_shells('0, SHELLS);
    send_item(make_query('0, '0, '0));
    send_item(make_query(HALF_RANGE, HALF_RANGE, HALF_RANGE));
    send_item(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(on_axis(radius_tbl[0]));
    send_item(on_axis(radius_tbl[100] - 1));
    // points on the inner radius and on the last shell in use
    set_shells(radius_tbl[10], 20);
    send_item(on_axis(radius_tbl[10]));
    send_item(on_axis(radius_tbl[10] - 1));
    send_item(on_axis(radius_tbl[19]));
    send_item(on_axis(radius_tbl[19] - 1));
    // inner radius past the outermost shell: the inner test wins
    set_shells(radius_tbl[50], 10);
    send_item(on_axis(radius_tbl[20]));
    send_item(on_axis(radius_tbl[60]));
    // shell count zero acts as one
    set_shells('0, '0);
    send_item(make_query('0, '0, '0));
    send_item(on_axis(radius_tbl[0]));
    // counts above the table clamp to the table size
    set_shells('0, 511);
    send_item(make_query(32'h7FFF_FFFF, HALF_RANGE, 32'h7FFF_FFFF));
    set_shells('0, SHELLS + 1);
    send_item(on_axis(radius_tbl[200]));
    set_shells('1, SHELLS);
    send_item(make_query(HALF_RANGE, HALF_RANGE, HALF_RANGE));
    send_item(make_query('0, '0, '0));
  endtask

  task automatic test_random_shells();
    for (int ph = 0; ph < 6; ph++) begin
      random_shells();
      idle_on = (ph != 0);
      run_mix(200, 8, 1'b1);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_shells('0, SHELLS);
    idle_on = 1'b0;
    hold_toggle <= ~hold_toggle;
    run_mix(40, 0, 1'b1);
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_unordered_table();
    random_shells();
    run_mix(250, 30, 1'b0);
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (zone_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing pending: status %0d zone %0d", res.status, res.zone);
      end else begin
        want = zone_q.pop_front();
        n_status[want.status]++;
        if (res.status !== want.status) note_mismatch("status", want.status, res.status);
        if (res.zone !== want.zone) note_mismatch("zone", want.zone, res.zone);
      end
    end
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD;
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (!idle_on) begin
      res_ready <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 2));
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY: res_ready <= 1'b1;
        RX_CHOPPY: res_ready <= $urandom_range(0, 1);
        default: res_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_corner_points();
    test_random_shells();
    test_output_backpressure();
    test_unordered_table();
    settle();
    $display("zone queries checked: %0d inside, %0d below inner radius, %0d beyond last shell",
             n_status[STATUS_INSIDE], n_status[STATUS_BELOW], n_status[STATUS_BEYOND]);
    $display("table loads: %0d, register settings: %0d, mismatches: %0d",
             n_loads, n_cfg, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
